[hw/rtl/card_detect_speed_fallback_assert.svh]
// Assertion macros for the card detect block.
// Each macro expands to one labelled concurrent assertion on the given clock,
// switched off while the active-low reset is asserted.
`ifndef CARD_DETECT_SPEED_FALLBACK_ASSERT_SVH
`define CARD_DETECT_SPEED_FALLBACK_ASSERT_SVH

// Same-cycle implication
`define CDSF_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("cdsf assertion failed");

// Next-cycle implication
`define CDSF_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("cdsf assertion failed");

`endif

[hw/rtl/cdsf_pkg.sv]
package cdsf_pkg;

    // sizing
    localparam int NUM_SPEEDS = 5;
    localparam int TIME_W     = 32;
    localparam int SPEED_W    = 3;
    localparam int MS_W       = 16;
    localparam int MODE_W     = 2;
    localparam int PHASE_W    = 2;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 16;

    localparam logic [SPEED_W-1:0] SPEED_MAX = SPEED_W'(NUM_SPEEDS - 1);

    // request modes
    localparam logic [MODE_W-1:0] MODE_POLL      = 2'd0;
    localparam logic [MODE_W-1:0] MODE_OUTCOME   = 2'd1;
    localparam logic [MODE_W-1:0] MODE_DOWNGRADE = 2'd2;
    localparam logic [MODE_W-1:0] MODE_NOP       = 2'd3;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_DEBOUNCE = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_SETTLE   = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_HOLDOFF  = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_START    = 2'd3;

    // configuration reset values
    localparam logic [MS_W-1:0]    DEBOUNCE_RST    = 16'd250;
    localparam logic [MS_W-1:0]    SETTLE_RST      = 16'd200;
    localparam logic [MS_W-1:0]    HOLDOFF_RST     = 16'd2000;
    localparam logic [SPEED_W-1:0] START_SPEED_RST = 3'd4;

    typedef enum logic [PHASE_W-1:0] {
        PH_IDLE      = 2'd0,
        PH_SETTLE    = 2'd1,
        PH_NEGOTIATE = 2'd2,
        PH_DOWNGRADE = 2'd3
    } t_phase;

    typedef struct packed {
        logic [MODE_W-1:0] mode;
        logic              cd_level;
        logic [TIME_W-1:0] now_ms;
        logic              attempt_ok;
    } t_req;

    typedef struct packed {
        logic               attempt_request;
        logic [SPEED_W-1:0] attempt_index;
        logic               unmount_now;
        logic               event_valid;
        logic               event_present;
        logic               mounted_flag;
        logic [SPEED_W-1:0] speed_now;
        logic [PHASE_W-1:0] phase_now;
        logic               downgrade_refused;
        logic               gave_up;
    } t_rsp;

    // start speed limited to the fastest speed that exists
    function automatic logic [SPEED_W-1:0] clamp_speed(input logic [SPEED_W-1:0] s);
        return (s > SPEED_MAX) ? SPEED_MAX : s;
    endfunction

endpackage

[hw/rtl/cdsf_req_if.sv]
interface cdsf_req_if;
    import cdsf_pkg::*;

    logic              valid;
    logic              ready;
    logic [MODE_W-1:0] mode;
    logic              cd_level;
    logic [TIME_W-1:0] now_ms;
    logic              attempt_ok;

    modport source (output valid, output mode, output cd_level, output now_ms,
                    output attempt_ok, input ready);
    modport sink   (input valid, input mode, input cd_level, input now_ms,
                    input attempt_ok, output ready);
endinterface

[hw/rtl/cdsf_rsp_if.sv]
interface cdsf_rsp_if;
    import cdsf_pkg::*;

    logic               valid;
    logic               ready;
    logic               attempt_request;
    logic [SPEED_W-1:0] attempt_index;
    logic               unmount_now;
    logic               event_valid;
    logic               event_present;
    logic               mounted_flag;
    logic [SPEED_W-1:0] speed_now;
    logic [PHASE_W-1:0] phase_now;
    logic               downgrade_refused;
    logic               gave_up;

    modport source (output valid, output attempt_request, output attempt_index,
                    output unmount_now, output event_valid, output event_present,
                    output mounted_flag, output speed_now, output phase_now,
                    output downgrade_refused, output gave_up, input ready);
    modport sink   (input valid, input attempt_request, input attempt_index,
                    input unmount_now, input event_valid, input event_present,
                    input mounted_flag, input speed_now, input phase_now,
                    input downgrade_refused, input gave_up, output ready);
endinterface

[hw/rtl/card_detect_speed_fallback.sv]
// Debounced card detect with bus-clock fallback. Each request on i_req is a
// poll tick (raw active-low detect level plus millisecond time), an attempt
// outcome, a downgrade request or a no-op, and gives exactly one response on
// o_rsp with the attempt to make, unmount/event flags and the current status.
// A request is held in the input register, is decoded against the card
// state in a single pass and lands in the response register; one request
// is taken every cycle while the response side keeps up, and the sole loop
// is the state update from one request to the next. Configuration
// (debounce, settle, holdoff, start speed) is to be written on i_cfg_*
// only between requests, with no request in flight; the block itself
// does not enforce this.
module card_detect_speed_fallback (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_cfg_we,
    input  logic [cdsf_pkg::CFG_IDX_W-1:0]   i_cfg_idx,
    input  logic [cdsf_pkg::CFG_DATA_W-1:0]  i_cfg_data,
    cdsf_req_if.sink                         i_req,
    cdsf_rsp_if.source                       o_rsp
);
    import cdsf_pkg::*;

    // configuration
    logic [MS_W-1:0]    r_debounce_ms;
    logic [MS_W-1:0]    r_settle_ms;
    logic [MS_W-1:0]    r_holdoff_ms;
    logic [SPEED_W-1:0] r_start_speed;

    // card state
    logic               r_card_present, n_card_present;
    logic               r_pending_level, n_pending_level;
    logic [TIME_W-1:0]  r_pending_since, n_pending_since;
    logic [TIME_W-1:0]  r_retry_after, n_retry_after;
    t_phase             r_phase, n_phase;
    logic [TIME_W-1:0]  r_settle_since, n_settle_since;
    logic [SPEED_W-1:0] r_try_index, n_try_index;
    logic [SPEED_W-1:0] r_speed_index, n_speed_index;
    logic               r_mounted, n_mounted;

    // pipeline
    logic               r_in_vld;
    t_req               r_in;
    logic               r_out_vld;
    t_rsp               r_out;
    t_rsp               n_out;
    logic               w_adv;
    logic               w_fire;

    // derived terms
    logic               w_present_now;
    logic [SPEED_W-1:0] w_first_speed;
    logic [TIME_W-1:0]  w_since_pending;
    logic [TIME_W-1:0]  w_since_settle;
    logic               w_in_holdoff;
    logic               w_settle_done;
    logic               w_debounce_ok;

    // handshake: response register frees the pass, input register frees i_req
    assign w_adv       = !r_out_vld || o_rsp.ready;
    assign w_fire      = r_in_vld && w_adv;
    assign i_req.ready = !r_in_vld || w_adv;

    // configuration writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_debounce_ms <= DEBOUNCE_RST;
            r_settle_ms   <= SETTLE_RST;
            r_holdoff_ms  <= HOLDOFF_RST;
            r_start_speed <= START_SPEED_RST;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_DEBOUNCE: r_debounce_ms <= i_cfg_data;
                CFG_SETTLE:   r_settle_ms   <= i_cfg_data;
                CFG_HOLDOFF:  r_holdoff_ms  <= i_cfg_data;
                CFG_START:    r_start_speed <= i_cfg_data[SPEED_W-1:0];
                default:      r_start_speed <= r_start_speed;
            endcase
        end
    end

    // input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_vld <= 1'b0;
        end else if (i_req.ready) begin
            r_in_vld <= i_req.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_req.ready && i_req.valid) begin
            r_in.mode       <= i_req.mode;
            r_in.cd_level   <= i_req.cd_level;
            r_in.now_ms     <= i_req.now_ms;
            r_in.attempt_ok <= i_req.attempt_ok;
        end
    end

    assign w_present_now   = !r_in.cd_level;
    assign w_first_speed   = clamp_speed(r_start_speed);
    assign w_since_pending = r_in.now_ms - r_pending_since;
    assign w_since_settle  = r_in.now_ms - r_settle_since;
    assign w_in_holdoff    = (r_retry_after != '0) && (r_in.now_ms < r_retry_after);

    // settle window over; stable level that differs from the card state, outside the holdoff
    assign w_settle_done = (w_since_settle >= TIME_W'(r_settle_ms));
    assign w_debounce_ok = (w_present_now == r_pending_level) &&
                           (w_present_now != r_card_present) &&
                           (w_since_pending >= TIME_W'(r_debounce_ms)) &&
                           !w_in_holdoff;

    // next state for the request in the input register
    always_comb begin
        n_card_present  = r_card_present;
        n_pending_level = r_pending_level;
        n_pending_since = r_pending_since;
        n_retry_after   = r_retry_after;
        n_phase         = r_phase;
        n_settle_since  = r_settle_since;
        n_try_index     = r_try_index;
        n_speed_index   = r_speed_index;
        n_mounted       = r_mounted;

        case (r_in.mode)
            MODE_POLL: begin
                if (r_phase == PH_SETTLE) begin
                    if (w_settle_done) begin
                        n_phase     = PH_NEGOTIATE;
                        n_try_index = w_first_speed;
                    end
                end else if (r_phase == PH_IDLE) begin
                    if (w_present_now != r_pending_level) begin
                        n_pending_level = w_present_now;
                        n_pending_since = r_in.now_ms;
                    end else if (w_debounce_ok) begin
                        n_card_present = w_present_now;
                        if (!w_present_now) begin
                            n_mounted = 1'b0;
                        end else begin
                            n_phase        = PH_SETTLE;
                            n_settle_since = r_in.now_ms;
                        end
                    end
                end
            end
            MODE_OUTCOME: begin
                if (r_phase == PH_NEGOTIATE) begin
                    if (r_in.attempt_ok) begin
                        n_speed_index = r_try_index;
                        n_mounted     = 1'b1;
                        n_phase       = PH_IDLE;
                        n_retry_after = '0;
                    end else if (r_try_index == '0) begin
                        // every speed failed: drop the card and arm the holdoff
                        n_phase        = PH_IDLE;
                        n_card_present = 1'b0;
                        n_retry_after  = r_in.now_ms + TIME_W'(r_holdoff_ms);
                    end else begin
                        n_try_index = r_try_index - 1'b1;
                    end
                end else if (r_phase == PH_DOWNGRADE) begin
                    if (r_in.attempt_ok) begin
                        n_speed_index = r_try_index;
                        n_mounted     = 1'b1;
                    end
                    n_phase = PH_IDLE;
                end
            end
            MODE_DOWNGRADE: begin
                if (r_phase == PH_IDLE && r_speed_index != '0) begin
                    n_try_index = r_speed_index - 1'b1;
                    n_phase     = PH_DOWNGRADE;
                end
            end
            MODE_NOP: begin
                n_phase = r_phase;
            end
            default: begin
                n_phase = r_phase;
            end
        endcase
    end

    // response fields for the request in the input register
    always_comb begin
        n_out = '0;

        case (r_in.mode)
            MODE_POLL: begin
                if (r_phase == PH_SETTLE) begin
                    if (w_settle_done) begin
                        n_out.attempt_request = 1'b1;
                        n_out.attempt_index   = w_first_speed;
                    end
                end else if (r_phase == PH_IDLE) begin
                    // removal confirmed
                    if (w_debounce_ok && !w_present_now) begin
                        n_out.unmount_now = 1'b1;
                        n_out.event_valid = 1'b1;
                    end
                end
            end
            MODE_OUTCOME: begin
                if (r_phase == PH_NEGOTIATE) begin
                    if (r_in.attempt_ok) begin
                        n_out.event_valid   = 1'b1;
                        n_out.event_present = 1'b1;
                    end else if (r_try_index == '0) begin
                        n_out.gave_up = 1'b1;
                    end else begin
                        n_out.attempt_request = 1'b1;
                        n_out.attempt_index   = r_try_index - 1'b1;
                    end
                end
            end
            MODE_DOWNGRADE: begin
                if (r_phase == PH_IDLE) begin
                    if (r_speed_index == '0) begin
                        n_out.downgrade_refused = 1'b1;
                    end else begin
                        n_out.attempt_request = 1'b1;
                        n_out.attempt_index   = r_speed_index - 1'b1;
                    end
                end
            end
            default: ;
        endcase

        n_out.mounted_flag = n_mounted;
        n_out.speed_now    = n_speed_index;
        n_out.phase_now    = n_phase;
    end

    // state update, one request per cycle while the response side keeps up
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_card_present  <= 1'b0;
            r_pending_level <= 1'b0;
            r_pending_since <= '0;
            r_retry_after   <= '0;
            r_phase         <= PH_IDLE;
            r_settle_since  <= '0;
            r_try_index     <= '0;
            r_speed_index   <= clamp_speed(START_SPEED_RST);
            r_mounted       <= 1'b0;
        end else if (w_fire) begin
            r_card_present  <= n_card_present;
            r_pending_level <= n_pending_level;
            r_pending_since <= n_pending_since;
            r_retry_after   <= n_retry_after;
            r_phase         <= n_phase;
            r_settle_since  <= n_settle_since;
            r_try_index     <= n_try_index;
            r_speed_index   <= n_speed_index;
            r_mounted       <= n_mounted;
        end
    end

    // response register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (w_adv) begin
            r_out_vld <= r_in_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_fire) begin
            r_out <= n_out;
        end
    end

    assign o_rsp.valid             = r_out_vld;
    assign o_rsp.attempt_request   = r_out.attempt_request;
    assign o_rsp.attempt_index     = r_out.attempt_index;
    assign o_rsp.unmount_now       = r_out.unmount_now;
    assign o_rsp.event_valid       = r_out.event_valid;
    assign o_rsp.event_present     = r_out.event_present;
    assign o_rsp.mounted_flag      = r_out.mounted_flag;
    assign o_rsp.speed_now         = r_out.speed_now;
    assign o_rsp.phase_now         = r_out.phase_now;
    assign o_rsp.downgrade_refused = r_out.downgrade_refused;
    assign o_rsp.gave_up           = r_out.gave_up;

    // checks
    `include "card_detect_speed_fallback_assert.svh"

    // a card in its settle window has been seen as present
    `CDSF_ASSERT_IMPL(a_settle_present, i_clk, i_rst_n, r_phase == PH_SETTLE, r_card_present)
    // an outstanding attempt always names a speed that exists
    `CDSF_ASSERT_IMPL(a_try_range, i_clk, i_rst_n,
        r_phase == PH_NEGOTIATE || r_phase == PH_DOWNGRADE, r_try_index <= SPEED_MAX)
    // a give-up request leaves the block idle with the card dropped
    `CDSF_ASSERT_NEXT(a_gave_up_idle, i_clk, i_rst_n, w_fire && n_out.gave_up,
        r_phase == PH_IDLE && !r_card_present)

endmodule
